// ===== rtl/trmm_pkg.sv =====
// Shared types and constants for the tile run rectangle merger.
// No dependencies; imported by trmm_scaler and the top level.
package trmm_pkg;

    localparam int SYM_W       = 8;
    localparam int PPC_W       = 8;
    localparam int X_W         = 14;
    localparam int Y_W         = 16;
    localparam int W_W         = 14;
    localparam int H_W         = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 64;

    // results per request beyond this count are dropped
    localparam int OUT_LIMIT   = 64;
    localparam int OUT_CNT_W   = 7;

    localparam logic [PPC_W-1:0] PPC_RESET = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIXEL_PER_CELL = 3'd0,
        REG_SOLID_A        = 3'd1,
        REG_SOLID_B        = 3'd2,
        REG_SOLID_C        = 3'd3,
        REG_SOLID_D        = 3'd4
    } cfg_reg_t;

    // packed so that rect_x lands in the lowest bits
    typedef struct packed {
        logic [H_W-1:0] rect_height;
        logic [W_W-1:0] rect_width;
        logic [Y_W-1:0] rect_y;
        logic [X_W-1:0] rect_x;
    } rect_t;

endpackage

// ===== rtl/trmm_scaler.sv =====
// Rectangle scaler: one shared multiplier turns cell units into pixels,
// one field per cycle. Depends on trmm_pkg.
module trmm_scaler #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 256,
    localparam int XW = $clog2(MAX_COLS),
    localparam int YW = $clog2(MAX_ROWS),
    localparam int WW = $clog2(MAX_COLS + 1),
    localparam int HW = $clog2(MAX_ROWS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [trmm_pkg::PPC_W-1:0] ppc,
    input  logic [XW-1:0]              col_first,
    input  logic [YW-1:0]              row_top,
    input  logic [WW-1:0]              col_span,
    input  logic [HW-1:0]              row_span,
    output logic                       busy,
    output trmm_pkg::rect_t            rect
);
    import trmm_pkg::*;

    localparam int OPW = (WW > HW) ? WW : HW;
    localparam int PW  = OPW + PPC_W;

    typedef enum logic [1:0] {
        STEP_X,
        STEP_Y,
        STEP_W,
        STEP_H
    } step_t;

    step_t            step_reg;
    logic             busy_reg;
    logic [XW-1:0]    x_reg;
    logic [YW-1:0]    y_reg;
    logic [WW-1:0]    w_reg;
    logic [HW-1:0]    h_reg;
    logic [PPC_W-1:0] ppc_reg;
    rect_t            rect_reg;
    logic [OPW-1:0]   op;
    logic [PW-1:0]    prod;

    always_comb
    begin
        case (step_reg)
            STEP_X:  op = OPW'(x_reg);
            STEP_Y:  op = OPW'(y_reg);
            STEP_W:  op = OPW'(w_reg);
            STEP_H:  op = OPW'(h_reg);
            default: op = '0;
        endcase
    end

    assign prod = op * ppc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_X;
            busy_reg <= 1'b0;
            x_reg    <= '0;
            y_reg    <= '0;
            w_reg    <= '0;
            h_reg    <= '0;
            ppc_reg  <= '0;
            rect_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_X;
            busy_reg <= 1'b1;
            x_reg    <= col_first;
            y_reg    <= row_top;
            w_reg    <= col_span;
            h_reg    <= row_span;
            ppc_reg  <= ppc;
        end
        else if (busy_reg)
        begin
            case (step_reg)
                STEP_X:  rect_reg.rect_x      <= X_W'(prod);
                STEP_Y:  rect_reg.rect_y      <= Y_W'(prod);
                STEP_W:  rect_reg.rect_width  <= W_W'(prod);
                STEP_H:  rect_reg.rect_height <= H_W'(prod);
                default: ;
            endcase
            if (step_reg == STEP_H)
            begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_t'(step_reg + 2'd1);
        end
    end

    assign busy = busy_reg;
    assign rect = rect_reg;

endmodule

// ===== rtl/tile_run_rectangle_merger_unit.sv =====
// Tile run rectangle merger, top level: cell stream in, rectangle stream out.
// Depends on trmm_pkg and trmm_scaler.
//
// Input: one map cell per request; s_tdata is the symbol, s_tuser marks the
// last cell of a row, s_tlast the last cell of the map (it also ends the row).
// Output: one closed rectangle per request, in pixels; m_tlast marks the last
// rectangle caused by one cell. Config port: cfg_write/cfg_index/cfg_data,
// write only while idle.
// Sequence: a cell that closes no run and ends no row stays in idle. Closing a
// run passes CLOSE, then MREQ and MCHK for each row-above entry compared, then
// CWR (or EMIT when the table is full). A row end walks the runs above through
// FIN and PCHK, with an EMIT for each run emitted; a map end then walks the
// finished row through CREQ, CCHK and EMIT per run. Every other cell ends in DONE.
// The shared multiplier holds one rectangle at a time, so rectangles start
// only once it is free again.
// Stalls: the last rectangle of a cell waits in a one-deep hold stage, so a
// stalled receiver stops the walk only when the output register and the hold
// stage are both full; the next cell is taken while the output register waits.
// Reset: counters, run state and registers back to defaults; the run tables
// need no clearing, since entries are only read below the fill counts.
module tile_run_rectangle_merger_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 256,
    parameter int MAX_RUNS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_write,
    input  logic [trmm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trmm_pkg::PPC_W-1:0]       cfg_data,
    // cell stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [trmm_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] cell_symbol
    input  logic                             s_tuser,   // [0] row_end
    input  logic                             s_tlast,   // map_end
    // rectangle stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [13:0] rect_x, [29:14] rect_y, [43:30] rect_width, [59:44] rect_height
    output logic [trmm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast    // last_rect
);
    import trmm_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);         // column index
    localparam int CCW = $clog2(MAX_COLS + 1);     // column counter / span
    localparam int RW  = $clog2(MAX_ROWS);         // row index
    localparam int RCW = $clog2(MAX_ROWS + 1);     // row counter / span
    localparam int IW  = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
    localparam int NW  = $clog2(MAX_RUNS + 1);     // run count

    typedef struct packed {
        logic [CW-1:0] col_first;
        logic [CW-1:0] col_last;
        logic [RW-1:0] row_top;
    } run_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLOSE,   // run closes: table full check
        ST_MREQ,    // read row-above entry at match pointer
        ST_MCHK,    // compare span
        ST_CWR,     // store run in current row table
        ST_POSTC,   // after a run emitted directly
        ST_FIN,     // row end: read row-above entry
        ST_PCHK,    // emit it unless continued
        ST_CREQ,    // map end: read current row entry
        ST_CCHK,    // emit it
        ST_EMIT,    // hand rectangle to scaler
        ST_DONE     // flush held rectangle with last mark
    } state_t;

    // configuration
    logic [PPC_W-1:0] ppc_reg;
    logic [SYM_W-1:0] sym_a_reg;
    logic [SYM_W-1:0] sym_b_reg;
    logic [SYM_W-1:0] sym_c_reg;
    logic [SYM_W-1:0] sym_d_reg;

    // sequencer and scan state
    state_t            state_reg;
    state_t            ret_reg;
    logic [CCW-1:0]    col_reg;
    logic [RCW-1:0]    row_reg;
    logic              run_open_reg;
    logic [CW-1:0]     start_reg;
    logic [CW-1:0]     last_reg;
    logic [RW-1:0]     top_reg;
    logic              end_reg;
    logic              map_reg;
    logic              sel_reg;          // bank that holds the row above
    logic [NW-1:0]     prev_count_reg;
    logic [NW-1:0]     cur_count_reg;
    logic [NW-1:0]     pm_reg;           // match pointer into row above
    logic [NW-1:0]     walk_reg;
    logic [MAX_RUNS-1:0] kept_reg;       // row-above run continued this row
    logic [OUT_CNT_W-1:0] out_cnt_reg;

    // rectangle to emit, cell units
    logic [CW-1:0]     em_x_reg;
    logic [RW-1:0]     em_y_reg;
    logic [CCW-1:0]    em_w_reg;
    logic [RCW-1:0]    em_h_reg;

    // output side
    logic              pend_valid_reg;
    logic              out_valid_reg;
    logic              out_last_reg;
    rect_t             out_rect_reg;

    // run tables, ping-pong banks
    run_entry_t        run_mem [0:1][0:MAX_RUNS-1];
    run_entry_t        rd_reg;
    logic              mem_we;
    logic              mem_re;
    logic              rd_bank;
    logic [IW-1:0]     rd_idx;
    run_entry_t        wr_entry;

    // scaler link
    logic              sc_start;
    logic              sc_busy;
    rect_t             sc_rect;
    logic              can_move;

    // cell decode
    logic              sym_hit;
    logic              solid;
    logic              end_any;
    logic              need_close;
    logic [CW-1:0]     start_now;
    logic [CW-1:0]     close_last_now;

    function automatic logic match_list(input logic [SYM_W-1:0] s,
                                        input logic [SYM_W-1:0] a,
                                        input logic [SYM_W-1:0] b,
                                        input logic [SYM_W-1:0] c,
                                        input logic [SYM_W-1:0] d);
        // list ends at the first zero entry
        logic hit;
        hit = 1'b0;
        if (a != '0)
        begin
            if (a == s)
                hit = 1'b1;
            else if (b != '0)
            begin
                if (b == s)
                    hit = 1'b1;
                else if (c != '0)
                begin
                    if (c == s)
                        hit = 1'b1;
                    else if (d != '0 && d == s)
                        hit = 1'b1;
                end
            end
        end
        return hit;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppc_reg   <= PPC_RESET;
            sym_a_reg <= '0;
            sym_b_reg <= '0;
            sym_c_reg <= '0;
            sym_d_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_PIXEL_PER_CELL: ppc_reg   <= cfg_data;
                REG_SOLID_A:        sym_a_reg <= cfg_data;
                REG_SOLID_B:        sym_b_reg <= cfg_data;
                REG_SOLID_C:        sym_c_reg <= cfg_data;
                REG_SOLID_D:        sym_d_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign sym_hit = match_list(s_tdata[SYM_W-1:0], sym_a_reg, sym_b_reg,
                                sym_c_reg, sym_d_reg);
    assign solid = (col_reg < CCW'(MAX_COLS)) && (row_reg < RCW'(MAX_ROWS)) && sym_hit;
    assign end_any = s_tuser | s_tlast;
    assign need_close = solid ? end_any : run_open_reg;
    assign start_now = (solid && !run_open_reg) ? col_reg[CW-1:0] : start_reg;
    // a non-solid cell closes the run one column back
    assign close_last_now = solid ? col_reg[CW-1:0] : CW'(col_reg - 1'b1);

    assign can_move = !sc_busy && (!out_valid_reg || m_tready);
    assign sc_start = (state_reg == ST_EMIT) && (out_cnt_reg != OUT_CNT_W'(OUT_LIMIT))
                      && (!pend_valid_reg || can_move);

    // table port control
    always_comb
    begin
        mem_re  = 1'b0;
        rd_bank = sel_reg;
        rd_idx  = walk_reg[IW-1:0];
        mem_we  = (state_reg == ST_CWR);
        case (state_reg)
            ST_MREQ:
            begin
                mem_re = (pm_reg < prev_count_reg);
                rd_idx = pm_reg[IW-1:0];
            end
            ST_FIN:
            begin
                mem_re = (walk_reg < prev_count_reg);
            end
            ST_CREQ:
            begin
                mem_re  = (walk_reg < cur_count_reg);
                rd_bank = ~sel_reg;
            end
            default:
            begin
                mem_re = 1'b0;
            end
        endcase
    end

    assign wr_entry.col_first = start_reg;
    assign wr_entry.col_last  = last_reg;
    assign wr_entry.row_top   = top_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            run_mem[~sel_reg][cur_count_reg[IW-1:0]] <= wr_entry;
        end
        if (mem_re)
        begin
            rd_reg <= run_mem[rd_bank][rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ret_reg        <= ST_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            run_open_reg   <= 1'b0;
            start_reg      <= '0;
            last_reg       <= '0;
            top_reg        <= '0;
            end_reg        <= 1'b0;
            map_reg        <= 1'b0;
            sel_reg        <= 1'b0;
            prev_count_reg <= '0;
            cur_count_reg  <= '0;
            pm_reg         <= '0;
            walk_reg       <= '0;
            kept_reg       <= '0;
            out_cnt_reg    <= '0;
            em_x_reg       <= '0;
            em_y_reg       <= '0;
            em_w_reg       <= '0;
            em_h_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            out_rect_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        out_cnt_reg  <= '0;
                        walk_reg     <= '0;
                        end_reg      <= end_any;
                        map_reg      <= s_tlast;
                        start_reg    <= start_now;
                        last_reg     <= close_last_now;
                        run_open_reg <= solid && !end_any;
                        if (col_reg < CCW'(MAX_COLS))
                        begin
                            col_reg <= col_reg + 1'b1;
                        end
                        if (need_close)
                            state_reg <= ST_CLOSE;
                        else if (end_any)
                            state_reg <= ST_FIN;
                        else
                            state_reg <= ST_IDLE;
                    end
                end

                ST_CLOSE:
                begin
                    if (cur_count_reg == NW'(MAX_RUNS))
                    begin
                        // table full: one-row rectangle, no merging
                        em_x_reg  <= start_reg;
                        em_y_reg  <= row_reg[RW-1:0];
                        em_w_reg  <= CCW'(last_reg) - CCW'(start_reg) + CCW'(1);
                        em_h_reg  <= RCW'(1);
                        ret_reg   <= ST_POSTC;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_MREQ;
                    end
                end

                ST_MREQ:
                begin
                    if (pm_reg < prev_count_reg)
                    begin
                        state_reg <= ST_MCHK;
                    end
                    else
                    begin
                        top_reg   <= row_reg[RW-1:0];
                        state_reg <= ST_CWR;
                    end
                end

                ST_MCHK:
                begin
                    if (rd_reg.col_first < start_reg)
                    begin
                        pm_reg    <= pm_reg + 1'b1;
                        state_reg <= ST_MREQ;
                    end
                    else if (rd_reg.col_first == start_reg && rd_reg.col_last == last_reg)
                    begin
                        top_reg                     <= rd_reg.row_top;
                        kept_reg[pm_reg[IW-1:0]]    <= 1'b1;
                        pm_reg                      <= pm_reg + 1'b1;
                        state_reg                   <= ST_CWR;
                    end
                    else
                    begin
                        top_reg   <= row_reg[RW-1:0];
                        state_reg <= ST_CWR;
                    end
                end

                ST_CWR:
                begin
                    cur_count_reg <= cur_count_reg + 1'b1;
                    state_reg     <= end_reg ? ST_FIN : ST_DONE;
                end

                ST_POSTC:
                begin
                    state_reg <= end_reg ? ST_FIN : ST_DONE;
                end

                ST_FIN:
                begin
                    if (walk_reg < prev_count_reg)
                    begin
                        state_reg <= ST_PCHK;
                    end
                    else if (map_reg)
                    begin
                        walk_reg  <= '0;
                        state_reg <= ST_CREQ;
                    end
                    else
                    begin
                        // current row becomes the row above
                        sel_reg        <= ~sel_reg;
                        prev_count_reg <= cur_count_reg;
                        cur_count_reg  <= '0;
                        col_reg        <= '0;
                        pm_reg         <= '0;
                        kept_reg       <= '0;
                        if (row_reg < RCW'(MAX_ROWS))
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                        state_reg <= ST_DONE;
                    end
                end

                ST_PCHK:
                begin
                    walk_reg <= walk_reg + 1'b1;
                    if (!kept_reg[walk_reg[IW-1:0]])
                    begin
                        // bottom is the row before this one
                        em_x_reg  <= rd_reg.col_first;
                        em_y_reg  <= rd_reg.row_top;
                        em_w_reg  <= CCW'(rd_reg.col_last) - CCW'(rd_reg.col_first) + CCW'(1);
                        em_h_reg  <= row_reg - RCW'(rd_reg.row_top);
                        ret_reg   <= ST_FIN;
                        state_reg <= ST_EMIT;
                    end
                    else
                    begin
                        state_reg <= ST_FIN;
                    end
                end

                ST_CREQ:
                begin
                    if (walk_reg < cur_count_reg)
                    begin
                        state_reg <= ST_CCHK;
                    end
                    else
                    begin
                        prev_count_reg <= '0;
                        cur_count_reg  <= '0;
                        row_reg        <= '0;
                        col_reg        <= '0;
                        pm_reg         <= '0;
                        kept_reg       <= '0;
                        state_reg      <= ST_DONE;
                    end
                end

                ST_CCHK:
                begin
                    walk_reg  <= walk_reg + 1'b1;
                    em_x_reg  <= rd_reg.col_first;
                    em_y_reg  <= rd_reg.row_top;
                    em_w_reg  <= CCW'(rd_reg.col_last) - CCW'(rd_reg.col_first) + CCW'(1);
                    em_h_reg  <= row_reg - RCW'(rd_reg.row_top) + RCW'(1);
                    ret_reg   <= ST_CREQ;
                    state_reg <= ST_EMIT;
                end

                ST_EMIT:
                begin
                    if (out_cnt_reg == OUT_CNT_W'(OUT_LIMIT))
                    begin
                        state_reg <= ret_reg;
                    end
                    else if (!pend_valid_reg || can_move)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                            out_rect_reg  <= sc_rect;
                        end
                        pend_valid_reg <= 1'b1;
                        out_cnt_reg    <= out_cnt_reg + 1'b1;
                        state_reg      <= ret_reg;
                    end
                end

                ST_DONE:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (can_move)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        out_rect_reg   <= sc_rect;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    trmm_scaler #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (sc_start),
        .ppc       (ppc_reg),
        .col_first (em_x_reg),
        .row_top   (em_y_reg),
        .col_span  (em_w_reg),
        .row_span  (em_h_reg),
        .busy      (sc_busy),
        .rect      (sc_rect)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_rect_reg);
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_idle_nothing_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held rectangle left behind at idle");

    a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cur_count_reg <= NW'(MAX_RUNS) && prev_count_reg <= NW'(MAX_RUNS))
        else $error("run table count out of range");

    a_scaler_free: assert property (@(posedge clk) disable iff (!rst_n)
        sc_start |-> !sc_busy)
        else $error("scaler restarted while busy");

    a_out_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg <= OUT_CNT_W'(OUT_LIMIT))
        else $error("result count past limit");

    a_row_end_closed: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> !run_open_reg)
        else $error("run still open at row end");
`endif

endmodule
